// ===== hdl/sorted_event_table_insert_defines.svh =====
// Assertion macros for the sorted event table.
`ifndef SORTED_EVENT_TABLE_INSERT_DEFINES_SVH
`define SORTED_EVENT_TABLE_INSERT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SETI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define SETI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== hdl/seti_pkg.sv =====
// Shared types and constants of the sorted event table.
package seti_pkg;
	localparam logic [15:0] NOT_QUANTIZED = 16'hFFFF;
	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_RANGE = 2'd2;
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic        command;
		logic        use_quantized;
		logic [15:0] bar;
		logic [15:0] beat;
		logic [15:0] tick;
		logic [15:0] qbar;
		logic [15:0] qbeat;
		logic [15:0] qtick;
		logic [2:0]  instrument;
		logic [7:0]  status;
		logic [6:0]  key;
		logic [9:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  error;
		logic [9:0]  position;
		logic [10:0] entry_count;
		logic [15:0] out_bar;
		logic [15:0] out_beat;
		logic [15:0] out_tick;
		logic [15:0] out_qbar;
		logic [15:0] out_qbeat;
		logic [15:0] out_qtick;
		logic [2:0]  out_instrument;
		logic [7:0]  out_status;
		logic [6:0]  out_key;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_SHIFT, ST_SHIFT_WAIT, ST_WRITE, ST_READ,
		ST_DONE
	} state_t;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;       // capture the input item
		logic scan_start; // set address to zero
		logic scan_step;  // evaluate entry just read, advance
		logic shift_start;// set address to count
		logic shift_rd;   // read entry addr-1
		logic shift_wr;   // write entry addr, step down
		logic write_new;  // store note at position
		logic read_start; // read entry at read_index
		logic finish;     // build the result
	} cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic is_read;
		logic full;
		logic range_bad;
		logic scan_done;
		logic shift_done;
	} stat_t;
endpackage

// ===== hdl/seti_if.sv =====
// Valid/ready channel carrying one item of a given type.
interface seti_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/seti_ctrl.sv =====
// Controller state machine of the sorted event table.
module seti_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  seti_pkg::stat_t  stat,
	output seti_pkg::cmd_t   cmd
);
	seti_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= seti_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			seti_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = seti_pkg::ST_SCAN;
				end
			end
			seti_pkg::ST_SCAN: begin
				if (stat.is_read) begin
					cmd.read_start = 1'b1;
					state_d = seti_pkg::ST_READ;
				end else if (stat.full) begin
					cmd.finish = 1'b1;
					state_d = seti_pkg::ST_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = seti_pkg::ST_SCAN_WAIT;
				end
			end
			seti_pkg::ST_SCAN_WAIT: begin
				if (stat.scan_done) begin
					cmd.shift_start = 1'b1;
					state_d = seti_pkg::ST_SHIFT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			seti_pkg::ST_SHIFT: begin
				if (stat.shift_done) begin
					cmd.write_new = 1'b1;
					state_d = seti_pkg::ST_WRITE;
				end else begin
					cmd.shift_rd = 1'b1;
					state_d = seti_pkg::ST_SHIFT_WAIT;
				end
			end
			seti_pkg::ST_SHIFT_WAIT: begin
				cmd.shift_wr = 1'b1;
				state_d = seti_pkg::ST_SHIFT;
			end
			seti_pkg::ST_WRITE: begin
				cmd.finish = 1'b1;
				state_d = seti_pkg::ST_DONE;
			end
			seti_pkg::ST_READ: begin
				cmd.finish = 1'b1;
				state_d = seti_pkg::ST_DONE;
			end
			seti_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = seti_pkg::ST_IDLE;
				end
			end
			default: state_d = seti_pkg::ST_IDLE;
		endcase
	end
endmodule

// ===== hdl/seti_dpath.sv =====
// Datapath of the sorted event table: stores, scan logic and result register.
module seti_dpath #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  seti_pkg::in_item_t  in_data,
	input  seti_pkg::cmd_t      cmd,
	output seti_pkg::stat_t     stat,
	output seti_pkg::out_item_t out_data
);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [63:0] timing_mem [TABLE_DEPTH];
	logic [49:0] payload_mem [TABLE_DEPTH];
	logic [63:0] t_rd_q;
	logic [49:0] p_rd_q;

	seti_pkg::in_item_t item_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] addr_q;   // scan index / shift destination
	logic [CW-1:0] pos_q;    // insertion point
	logic          found_q;
	logic          rd_pend_q;
	logic          seen_bar_q;  // the run of equal bar has started
	logic          seen_tick_q; // the run of equal tick inside it has started
	logic          wrote_q;     // the current insert stored its note
	seti_pkg::out_item_t res_q;
	seti_pkg::out_item_t res_d;

	// Scan compare of the entry just read.
	logic [15:0] qb, qt, eb, et, nb, nt;
	logic        bar_ge, bar_gt, tick_ge, tick_gt, instr_ge;
	logic        in_bar, in_tick, stop_here;
	logic [AW-1:0] rd_addr;
	logic        rd_en;

	assign qb = t_rd_q[47:32];
	assign qt = t_rd_q[63:48];
	assign eb = (item_q.use_quantized && qb != seti_pkg::NOT_QUANTIZED) ? qb : t_rd_q[15:0];
	assign et = (item_q.use_quantized && qt != seti_pkg::NOT_QUANTIZED) ? qt : t_rd_q[31:16];
	assign nb = (item_q.use_quantized && qb != seti_pkg::NOT_QUANTIZED) ? item_q.qbar
		: item_q.bar;
	assign nt = (item_q.use_quantized && qt != seti_pkg::NOT_QUANTIZED) ? item_q.qtick
		: item_q.tick;
	assign bar_ge = eb >= nb;
	assign bar_gt = eb > nb;
	assign tick_ge = et >= nt;
	assign tick_gt = et > nt;
	assign instr_ge = p_rd_q[34:32] >= item_q.instrument;
	assign in_bar = seen_bar_q || bar_ge;
	assign in_tick = seen_tick_q || tick_ge;
	// The note goes where the equal-bar run ends, where the equal-tick run inside it
	// ends, or at the first entry of that tick run whose instrument is not lower.
	assign stop_here = in_bar && (bar_gt || (in_tick && (tick_gt || instr_ge)));

	assign stat.is_read = item_q.command == seti_pkg::CMD_READ;
	assign stat.full = count_q >= CW'(TABLE_DEPTH);
	assign stat.range_bad = 32'(item_q.read_index) >= 32'(count_q) ||
		32'(item_q.read_index) >= 32'(TABLE_DEPTH);
	assign stat.scan_done = found_q || (!rd_pend_q && addr_q >= count_q);
	assign stat.shift_done = addr_q == pos_q;

	// Memory read address.
	always_comb begin
		rd_en = 1'b0;
		rd_addr = addr_q[AW-1:0];
		if (cmd.scan_start) begin
			rd_en = 1'b1;
			rd_addr = '0;
		end else if (cmd.scan_step) begin
			rd_en = 1'b1;
			rd_addr = AW'(addr_q + CW'(1));
		end else if (cmd.shift_rd) begin
			rd_en = 1'b1;
			rd_addr = AW'(addr_q - CW'(1));
		end else if (cmd.read_start) begin
			rd_en = 1'b1;
			rd_addr = AW'(item_q.read_index);
		end
	end

	// Memories, written and read in clocked blocks.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			t_rd_q <= timing_mem[rd_addr];
			p_rd_q <= payload_mem[rd_addr];
		end
		if (cmd.shift_wr) begin
			timing_mem[addr_q[AW-1:0]] <= t_rd_q;
			payload_mem[addr_q[AW-1:0]] <= p_rd_q;
		end else if (cmd.write_new) begin
			timing_mem[pos_q[AW-1:0]] <= {item_q.qtick, item_q.qbar, item_q.tick,
				item_q.bar};
			payload_mem[pos_q[AW-1:0]] <= {item_q.key, item_q.status,
				item_q.instrument, item_q.qbeat, item_q.beat};
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
	end

	// Scan and shift control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			addr_q <= '0;
			pos_q <= '0;
			found_q <= 1'b0;
			rd_pend_q <= 1'b0;
			seen_bar_q <= 1'b0;
			seen_tick_q <= 1'b0;
			wrote_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				wrote_q <= 1'b0;
			end else if (cmd.write_new) begin
				wrote_q <= 1'b1;
			end
			if (cmd.scan_start) begin
				addr_q <= '0;
				found_q <= 1'b0;
				rd_pend_q <= count_q != '0;
				pos_q <= count_q;
				seen_bar_q <= 1'b0;
				seen_tick_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// addr_q names the entry held in the read register.
				if (rd_pend_q && stop_here) begin
					found_q <= 1'b1;
					pos_q <= addr_q;
				end else if (rd_pend_q) begin
					seen_bar_q <= in_bar;
					seen_tick_q <= in_bar && in_tick;
					addr_q <= addr_q + CW'(1);
					rd_pend_q <= (addr_q + CW'(1)) < count_q;
				end
			end else if (cmd.shift_start) begin
				addr_q <= count_q;
			end else if (cmd.shift_wr) begin
				addr_q <= addr_q - CW'(1);
			end else if (cmd.write_new) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Result fields.
	always_comb begin
		res_d = '0;
		res_d.entry_count = 11'(count_q);
		if (stat.is_read) begin
			res_d.position = item_q.read_index;
			if (stat.range_bad) begin
				res_d.error = seti_pkg::ERR_RANGE;
			end else begin
				res_d.error = seti_pkg::ERR_OK;
				res_d.out_bar = t_rd_q[15:0];
				res_d.out_tick = t_rd_q[31:16];
				res_d.out_qbar = t_rd_q[47:32];
				res_d.out_qtick = t_rd_q[63:48];
				res_d.out_beat = p_rd_q[15:0];
				res_d.out_qbeat = p_rd_q[31:16];
				res_d.out_instrument = p_rd_q[34:32];
				res_d.out_status = p_rd_q[42:35];
				res_d.out_key = p_rd_q[49:43];
			end
		end else if (!wrote_q) begin
			res_d.error = seti_pkg::ERR_FULL;
		end else begin
			res_d.error = seti_pkg::ERR_OK;
			res_d.position = 10'(pos_q);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q <= res_d;
		end
	end

	assign out_data = res_q;
endmodule

// ===== hdl/sorted_event_table_insert.sv =====
// Sequence: a read result follows one table read; an insert result follows a scan up to
// the insertion index p and a shift of the count - p entries above it, each entry read
// and then written one place up, as the scan and the shift share the single read port.
// Throughput: one item at a time; the next input waits until the result is taken.
// Reset: arst_n empties the table at once; no clearing pass is needed.
module sorted_event_table_insert #(
	parameter int TABLE_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	seti_if.sink   in_ch,
	seti_if.source out_ch
);
	seti_pkg::cmd_t  cmd;
	seti_pkg::stat_t stat;

	seti_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	seti_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_ch.data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_ch.data)
	);
endmodule

// ===== hdl/seti_checker.sv =====
// Port-level checker for the sorted event table, bound to the top level.
`include "sorted_event_table_insert_defines.svh"
module seti_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input seti_pkg::out_item_t out_data
);
	// Input is never taken while a result waits.
	`SETI_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// A transfer in is not followed directly by a result.
	`SETI_ASSERT_NEXT(a_no_instant, clk, arst_n, in_valid && in_ready, !out_valid)
	// Error codes stay within their defined set.
	`SETI_ASSERT_IMP(a_err_code, clk, arst_n, out_valid,
		out_data.error == seti_pkg::ERR_OK || out_data.error == seti_pkg::ERR_FULL ||
		out_data.error == seti_pkg::ERR_RANGE)
	// An ok insert or read refers to an index below the resulting count.
	`SETI_ASSERT_IMP(a_pos_in_count, clk, arst_n,
		out_valid && out_data.error == seti_pkg::ERR_OK,
		11'(out_data.position) < out_data.entry_count)
endmodule

bind sorted_event_table_insert seti_checker u_seti_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);
